// ----- sv/assert_macros.svh -----
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check a property on every edge once reset is released
`define C8IC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("c8ic assertion failed");
// check a property on every edge, reset included
`define C8IC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("c8ic assertion failed");
`else
`define C8IC_ASSERT(lbl, clk, rstn, prop)
`define C8IC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- sv/c8ic_pkg.sv -----
// ----------------------------------------------------------------------------
// c8ic_pkg
// types, codes and the font table of the chip-8 instruction core
// ----------------------------------------------------------------------------
package c8ic_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int STACK_DEPTH = 16;
    localparam int PIXEL_STORE = 2048;
    localparam int MEM_AW      = 12;

    localparam logic [11:0] PC_START   = 12'h200;
    localparam logic [6:0]  MAX_WIDTH  = 7'd64;
    localparam logic [5:0]  MAX_HEIGHT = 6'd32;
    localparam logic [7:0]  OPC_CLS    = 8'hE0;
    localparam logic [7:0]  OPC_RET    = 8'hEE;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_EXEC = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_PIX  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_UNIMPL = 2'd1;
    localparam logic [1:0] ST_OVER   = 2'd2;
    localparam logic [1:0] ST_UNDER  = 2'd3;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    localparam logic [3:0] GRP_SYS  = 4'h0;
    localparam logic [3:0] GRP_JP   = 4'h1;
    localparam logic [3:0] GRP_CALL = 4'h2;
    localparam logic [3:0] GRP_SE   = 4'h3;
    localparam logic [3:0] GRP_LD   = 4'h6;
    localparam logic [3:0] GRP_ADD  = 4'h7;
    localparam logic [3:0] GRP_LDI  = 4'hA;
    localparam logic [3:0] GRP_DRW  = 4'hD;

    localparam int FONT_BYTES = 80;
    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DISP, S_RDM, S_RDP, S_F2, S_F3, S_EX, S_CLR, S_RET,
        S_DIV, S_DIVY, S_Y0, S_ROW, S_ROWQ, S_COL, S_PWR, S_DEND, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        C_NONE, C_INIT, C_ACCEPT, C_MEM_WR, C_MEM_RD, C_PIX_RD, C_RDDONE_MEM,
        C_RDDONE_PIX, C_F1, C_F2, C_F3, C_EXEC, C_CLR, C_RET_LOAD, C_DIV_STEP,
        C_DIV_LOADY, C_Y0, C_ROW_RD, C_ROW_LATCH, C_ROW_NEXT, C_COL_NEXT,
        C_DRAW_RD, C_PIX_WR, C_DRAW_END, C_DONE
    } t_cmd;

    typedef enum logic [1:0] {
        K_DONE, K_CLR, K_RET, K_DRAW
    } t_kind;

    typedef struct packed {
        logic       init_last;
        logic       clr_last;
        logic       div_last;
        logic       div_y;
        logic       pix_ok;
        logic       row_end;
        logic       col_end;
        logic       draw_bit;
        t_kind      kind;
        logic [1:0] op;
    } t_dp_status;

endpackage

// ----- sv/c8ic_ram.sv -----
// ----------------------------------------------------------------------------
// c8ic_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module c8ic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/c8ic_ctrl.sv -----
// ----------------------------------------------------------------------------
// c8ic_ctrl
// sequencer of the chip-8 core: init sweep, load and read requests, fetch, execute, draw, result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module c8ic_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  c8ic_pkg::t_dp_status i_status,
    output c8ic_pkg::t_cmd      o_cmd
);

    c8ic_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= c8ic_pkg::S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = c8ic_pkg::C_NONE;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            c8ic_pkg::S_INIT: begin
                o_cmd = c8ic_pkg::C_INIT;
                if (i_status.init_last) n_state = c8ic_pkg::S_IDLE;
            end
            c8ic_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = c8ic_pkg::C_ACCEPT;
                    n_state = c8ic_pkg::S_DISP;
                end
            end
            c8ic_pkg::S_DISP: begin
                case (i_status.op)
                    c8ic_pkg::OP_LOAD: begin
                        o_cmd   = c8ic_pkg::C_MEM_WR;
                        n_state = c8ic_pkg::S_DONE;
                    end
                    c8ic_pkg::OP_READ: begin
                        o_cmd   = c8ic_pkg::C_MEM_RD;
                        n_state = c8ic_pkg::S_RDM;
                    end
                    c8ic_pkg::OP_PIX: begin
                        if (i_status.pix_ok) begin
                            o_cmd   = c8ic_pkg::C_PIX_RD;
                            n_state = c8ic_pkg::S_RDP;
                        end else begin
                            n_state = c8ic_pkg::S_DONE;
                        end
                    end
                    default: begin
                        o_cmd   = c8ic_pkg::C_F1;
                        n_state = c8ic_pkg::S_F2;
                    end
                endcase
            end
            c8ic_pkg::S_RDM: begin
                o_cmd   = c8ic_pkg::C_RDDONE_MEM;
                n_state = c8ic_pkg::S_DONE;
            end
            c8ic_pkg::S_RDP: begin
                o_cmd   = c8ic_pkg::C_RDDONE_PIX;
                n_state = c8ic_pkg::S_DONE;
            end
            c8ic_pkg::S_F2: begin
                o_cmd   = c8ic_pkg::C_F2;
                n_state = c8ic_pkg::S_F3;
            end
            c8ic_pkg::S_F3: begin
                o_cmd   = c8ic_pkg::C_F3;
                n_state = c8ic_pkg::S_EX;
            end
            c8ic_pkg::S_EX: begin
                o_cmd = c8ic_pkg::C_EXEC;
                case (i_status.kind)
                    c8ic_pkg::K_CLR:  n_state = c8ic_pkg::S_CLR;
                    c8ic_pkg::K_RET:  n_state = c8ic_pkg::S_RET;
                    c8ic_pkg::K_DRAW: n_state = c8ic_pkg::S_DIV;
                    default:          n_state = c8ic_pkg::S_DONE;
                endcase
            end
            c8ic_pkg::S_CLR: begin
                o_cmd = c8ic_pkg::C_CLR;
                if (i_status.clr_last) n_state = c8ic_pkg::S_DONE;
            end
            c8ic_pkg::S_RET: begin
                o_cmd   = c8ic_pkg::C_RET_LOAD;
                n_state = c8ic_pkg::S_DONE;
            end
            c8ic_pkg::S_DIV: begin
                o_cmd = c8ic_pkg::C_DIV_STEP;
                if (i_status.div_last) begin
                    n_state = i_status.div_y ? c8ic_pkg::S_Y0 : c8ic_pkg::S_DIVY;
                end
            end
            c8ic_pkg::S_DIVY: begin
                o_cmd   = c8ic_pkg::C_DIV_LOADY;
                n_state = c8ic_pkg::S_DIV;
            end
            c8ic_pkg::S_Y0: begin
                o_cmd   = c8ic_pkg::C_Y0;
                n_state = c8ic_pkg::S_ROW;
            end
            c8ic_pkg::S_ROW: begin
                if (i_status.row_end) begin
                    n_state = c8ic_pkg::S_DEND;
                end else begin
                    o_cmd   = c8ic_pkg::C_ROW_RD;
                    n_state = c8ic_pkg::S_ROWQ;
                end
            end
            c8ic_pkg::S_ROWQ: begin
                o_cmd   = c8ic_pkg::C_ROW_LATCH;
                n_state = c8ic_pkg::S_COL;
            end
            c8ic_pkg::S_COL: begin
                if (i_status.col_end) begin
                    o_cmd   = c8ic_pkg::C_ROW_NEXT;
                    n_state = c8ic_pkg::S_ROW;
                end else if (i_status.draw_bit && i_status.pix_ok) begin
                    o_cmd   = c8ic_pkg::C_DRAW_RD;
                    n_state = c8ic_pkg::S_PWR;
                end else begin
                    o_cmd = c8ic_pkg::C_COL_NEXT;
                end
            end
            c8ic_pkg::S_PWR: begin
                o_cmd   = c8ic_pkg::C_PIX_WR;
                n_state = c8ic_pkg::S_COL;
            end
            c8ic_pkg::S_DEND: begin
                o_cmd   = c8ic_pkg::C_DRAW_END;
                n_state = c8ic_pkg::S_DONE;
            end
            c8ic_pkg::S_DONE: begin
                // result slot frees up in the same cycle it is taken
                if (!r_out_valid || i_out_ready) begin
                    o_cmd       = c8ic_pkg::C_DONE;
                    n_out_valid = 1'b1;
                    n_state     = c8ic_pkg::S_IDLE;
                end
            end
            default: n_state = c8ic_pkg::S_INIT;
        endcase
    end

    assign o_in_ready  = (r_state == c8ic_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    `C8IC_ASSERT(a_busy_after_req, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready)
    `C8IC_ASSERT(a_done_slot_free, i_clk, i_rst_n, (o_cmd == c8ic_pkg::C_DONE) |-> (!r_out_valid || i_out_ready))
    `C8IC_ASSERT(a_done_shows, i_clk, i_rst_n, (o_cmd == c8ic_pkg::C_DONE) |=> (o_out_valid && o_in_ready))

endmodule

// ----- sv/c8ic_dp.sv -----
// ----------------------------------------------------------------------------
// c8ic_dp
// datapath of the chip-8 core: memories, registers, divider and draw walk
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module c8ic_dp #(
    parameter int STACK_DEPTH = c8ic_pkg::STACK_DEPTH,
    parameter int PIXEL_STORE = c8ic_pkg::PIXEL_STORE
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  c8ic_pkg::t_cmd       i_cmd,
    output c8ic_pkg::t_dp_status o_flags,
    input  logic [1:0]           i_operation,
    input  logic [11:0]          i_address,
    input  logic [7:0]           i_write_byte,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_index,
    input  logic [6:0]           i_cfg_data,
    output logic [7:0]           o_read_data,
    output logic [15:0]          o_opcode,
    output logic [11:0]          o_program_counter,
    output logic                 o_collision,
    output logic [1:0]           o_status
);

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int PAW = $clog2(PIXEL_STORE);
    localparam logic [12:0]    PS13     = 13'(PIXEL_STORE);
    localparam logic [11:0]    CLR_LAST = 12'(PIXEL_STORE - 1);
    localparam logic [SCW-1:0] SP_FULL  = SCW'(STACK_DEPTH);

    // architectural state
    logic [11:0]    r_pc, r_i;
    logic [7:0]     r_v [16];
    logic [SCW-1:0] r_sp;
    logic [6:0]     r_w;
    logic [5:0]     r_h;

    // per-request working registers
    logic [1:0]  r_op;
    logic [11:0] r_addr;
    logic [7:0]  r_wb;
    logic [7:0]  r_rd;
    logic [15:0] r_opc;
    logic        r_hit;
    logic [1:0]  r_st;
    logic [11:0] r_cnt;
    logic [7:0]  r_rem, r_num;
    logic        r_div_y;
    logic [6:0]  r_x0;
    logic [5:0]  r_y;
    logic [3:0]  r_row, r_col;
    logic [11:0] r_base;
    logic [7:0]  r_bits;

    // result register
    logic [7:0]  r_o_rd;
    logic [15:0] r_o_opc;
    logic [11:0] r_o_pc;
    logic        r_o_coll;
    logic [1:0]  r_o_st;

    logic [6:0]  eff_w;
    logic [5:0]  eff_h;
    logic [3:0]  grp, opx, opy;
    logic [7:0]  nn;
    logic [11:0] nnn;
    logic [3:0]  v_sel;
    logic [7:0]  v_rd;
    logic [7:0]  rem_sh, rem_nx, div_d;
    logic [7:0]  colx;
    logic [11:0] pix_p, pix_full;
    logic        sp_empty, sp_full;

    logic           mem_we;
    logic [11:0]    mem_waddr, mem_raddr;
    logic [7:0]     mem_wdata, mem_q;
    logic           pix_we;
    logic [PAW-1:0] pix_waddr;
    logic [0:0]     pix_wdata, pix_q;
    logic           stk_we;
    logic [SAW-1:0] stk_raddr;
    logic [11:0]    stk_q;

    assign eff_w = (r_w == 7'd0) ? 7'd1 :
                   ((r_w > c8ic_pkg::MAX_WIDTH) ? c8ic_pkg::MAX_WIDTH : r_w);
    assign eff_h = (r_h == 6'd0) ? 6'd1 :
                   ((r_h > c8ic_pkg::MAX_HEIGHT) ? c8ic_pkg::MAX_HEIGHT : r_h);

    assign grp = r_opc[15:12];
    assign opx = r_opc[11:8];
    assign opy = r_opc[7:4];
    assign nn  = r_opc[7:0];
    assign nnn = r_opc[11:0];

    assign v_sel = (i_cmd == c8ic_pkg::C_DIV_LOADY) ? opy : opx;
    assign v_rd  = r_v[v_sel];

    // one restoring step of the modulo by the display size
    assign div_d  = r_div_y ? {2'b00, eff_h} : {1'b0, eff_w};
    assign rem_sh = {r_rem[6:0], r_num[7]};
    assign rem_nx = (rem_sh >= div_d) ? (rem_sh - div_d) : rem_sh;

    assign colx     = {1'b0, r_x0} + {4'b0000, r_col};
    assign pix_p    = r_base + {5'd0, r_x0} + {8'd0, r_col};
    assign pix_full = (r_op == c8ic_pkg::OP_PIX) ? r_addr : pix_p;

    assign sp_empty = (r_sp == '0);
    assign sp_full  = (r_sp == SP_FULL);

    always_comb begin
        o_flags.init_last = (r_cnt == 12'hFFF);
        o_flags.clr_last  = (r_cnt == CLR_LAST);
        o_flags.div_last  = (r_cnt[2:0] == 3'd7);
        o_flags.div_y     = r_div_y;
        o_flags.pix_ok    = ({1'b0, pix_full} < PS13);
        o_flags.row_end   = (r_row >= r_opc[3:0]) || (r_y >= eff_h);
        o_flags.col_end   = r_col[3] || (colx >= {1'b0, eff_w});
        o_flags.draw_bit  = r_bits[3'd7 - r_col[2:0]];
        o_flags.op        = r_op;
        case (grp)
            c8ic_pkg::GRP_SYS: begin
                if (r_opc[11:8] == 4'h0 && nn == c8ic_pkg::OPC_CLS) begin
                    o_flags.kind = c8ic_pkg::K_CLR;
                end else if (r_opc[11:8] == 4'h0 && nn == c8ic_pkg::OPC_RET && !sp_empty) begin
                    o_flags.kind = c8ic_pkg::K_RET;
                end else begin
                    o_flags.kind = c8ic_pkg::K_DONE;
                end
            end
            c8ic_pkg::GRP_DRW: o_flags.kind = c8ic_pkg::K_DRAW;
            default:           o_flags.kind = c8ic_pkg::K_DONE;
        endcase
    end

    // memory ports
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_wb;
        case (i_cmd)
            c8ic_pkg::C_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = (r_cnt < 12'(c8ic_pkg::FONT_BYTES)) ?
                            c8ic_pkg::FONT[r_cnt[6:0]] : 8'h00;
            end
            c8ic_pkg::C_MEM_WR: mem_we = 1'b1;
            default: ;
        endcase
        case (i_cmd)
            c8ic_pkg::C_MEM_RD: mem_raddr = r_addr;
            c8ic_pkg::C_F2:     mem_raddr = r_pc + 12'd1;
            c8ic_pkg::C_ROW_RD: mem_raddr = r_i + {8'd0, r_row};
            default:            mem_raddr = r_pc;
        endcase
    end

    always_comb begin
        pix_we    = 1'b0;
        pix_waddr = r_cnt[PAW-1:0];
        pix_wdata = 1'b0;
        case (i_cmd)
            c8ic_pkg::C_INIT: pix_we = ({1'b0, r_cnt} < PS13);
            c8ic_pkg::C_CLR:  pix_we = 1'b1;
            c8ic_pkg::C_PIX_WR: begin
                pix_we    = 1'b1;
                pix_waddr = pix_p[PAW-1:0];
                pix_wdata = ~pix_q;
            end
            default: ;
        endcase
    end

    assign stk_we    = (i_cmd == c8ic_pkg::C_EXEC) && (grp == c8ic_pkg::GRP_CALL) && !sp_full;
    assign stk_raddr = SAW'(r_sp - SCW'(1));

    c8ic_ram #(.WIDTH(8), .DEPTH(c8ic_pkg::MEM_BYTES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    c8ic_ram #(.WIDTH(1), .DEPTH(PIXEL_STORE)) u_pix (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_waddr),
        .i_wdata (pix_wdata),
        .i_raddr (pix_full[PAW-1:0]),
        .o_rdata (pix_q)
    );

    c8ic_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stk (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_sp[SAW-1:0]),
        .i_wdata (r_pc),
        .i_raddr (stk_raddr),
        .o_rdata (stk_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= c8ic_pkg::PC_START;
            r_i   <= 12'd0;
            r_sp  <= '0;
            r_w   <= c8ic_pkg::MAX_WIDTH;
            r_h   <= c8ic_pkg::MAX_HEIGHT;
            r_cnt <= 12'd0;
            for (int k = 0; k < 16; k++) begin
                r_v[k] <= 8'd0;
            end
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == c8ic_pkg::CFG_WIDTH)  r_w <= i_cfg_data;
                if (i_cfg_index == c8ic_pkg::CFG_HEIGHT) r_h <= i_cfg_data[5:0];
            end
            case (i_cmd)
                c8ic_pkg::C_INIT: r_cnt <= r_cnt + 12'd1;
                c8ic_pkg::C_ACCEPT: begin
                    r_op   <= i_operation;
                    r_addr <= i_address;
                    r_wb   <= i_write_byte;
                    r_rd   <= 8'd0;
                    r_opc  <= 16'd0;
                    r_hit  <= 1'b0;
                    r_st   <= c8ic_pkg::ST_OK;
                    r_cnt  <= 12'd0;
                end
                c8ic_pkg::C_RDDONE_MEM: r_rd <= mem_q;
                c8ic_pkg::C_RDDONE_PIX: r_rd <= {7'd0, pix_q};
                c8ic_pkg::C_F2:         r_opc[15:8] <= mem_q;
                c8ic_pkg::C_F3: begin
                    r_opc[7:0] <= mem_q;
                    r_pc       <= r_pc + 12'd2;
                end
                c8ic_pkg::C_EXEC: begin
                    case (grp)
                        c8ic_pkg::GRP_SYS: begin
                            if (r_opc[11:8] == 4'h0 && nn == c8ic_pkg::OPC_CLS) begin
                                r_cnt <= 12'd0;
                            end else if (r_opc[11:8] == 4'h0 && nn == c8ic_pkg::OPC_RET) begin
                                if (sp_empty) r_st <= c8ic_pkg::ST_UNDER;
                                else          r_sp <= r_sp - SCW'(1);
                            end else begin
                                r_st <= c8ic_pkg::ST_UNIMPL;
                            end
                        end
                        c8ic_pkg::GRP_JP: r_pc <= nnn;
                        c8ic_pkg::GRP_CALL: begin
                            if (sp_full) begin
                                r_st <= c8ic_pkg::ST_OVER;
                            end else begin
                                r_sp <= r_sp + SCW'(1);
                                r_pc <= nnn;
                            end
                        end
                        c8ic_pkg::GRP_SE:  if (v_rd == nn) r_pc <= r_pc + 12'd2;
                        c8ic_pkg::GRP_LD:  r_v[opx] <= nn;
                        c8ic_pkg::GRP_ADD: r_v[opx] <= v_rd + nn;
                        c8ic_pkg::GRP_LDI: r_i <= nnn;
                        c8ic_pkg::GRP_DRW: begin
                            r_num   <= v_rd;
                            r_rem   <= 8'd0;
                            r_cnt   <= 12'd0;
                            r_div_y <= 1'b0;
                        end
                        default: r_st <= c8ic_pkg::ST_UNIMPL;
                    endcase
                end
                c8ic_pkg::C_CLR:      r_cnt <= r_cnt + 12'd1;
                c8ic_pkg::C_RET_LOAD: r_pc  <= stk_q;
                c8ic_pkg::C_DIV_STEP: begin
                    r_rem <= rem_nx;
                    r_num <= {r_num[6:0], 1'b0};
                    r_cnt <= r_cnt + 12'd1;
                end
                c8ic_pkg::C_DIV_LOADY: begin
                    r_x0    <= r_rem[6:0];
                    r_num   <= v_rd;
                    r_rem   <= 8'd0;
                    r_cnt   <= 12'd0;
                    r_div_y <= 1'b1;
                end
                c8ic_pkg::C_Y0: begin
                    r_y   <= r_rem[5:0];
                    r_row <= 4'd0;
                end
                c8ic_pkg::C_ROW_RD: begin
                    r_base <= {7'd0, r_y[4:0]} * {5'd0, eff_w};
                    r_col  <= 4'd0;
                end
                c8ic_pkg::C_ROW_LATCH: r_bits <= mem_q;
                c8ic_pkg::C_ROW_NEXT: begin
                    r_row <= r_row + 4'd1;
                    r_y   <= r_y + 6'd1;
                end
                c8ic_pkg::C_COL_NEXT: r_col <= r_col + 4'd1;
                c8ic_pkg::C_PIX_WR: begin
                    if (pix_q[0]) r_hit <= 1'b1;
                    r_col <= r_col + 4'd1;
                end
                c8ic_pkg::C_DRAW_END: r_v[15] <= {7'd0, r_hit};
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == c8ic_pkg::C_DONE) begin
            r_o_rd   <= r_rd;
            r_o_opc  <= r_opc;
            r_o_pc   <= r_pc;
            r_o_coll <= r_hit;
            r_o_st   <= r_st;
        end
    end

    assign o_read_data       = r_o_rd;
    assign o_opcode          = r_o_opc;
    assign o_program_counter = r_o_pc;
    assign o_collision       = r_o_coll;
    assign o_status          = r_o_st;

    `C8IC_ASSERT(a_sp_bound, i_clk, i_rst_n, r_sp <= SP_FULL)
    `C8IC_ASSERT(a_pix_wr_in_range, i_clk, i_rst_n, (i_cmd == c8ic_pkg::C_PIX_WR) |-> ({1'b0, pix_p} < PS13))
    `C8IC_ASSERT(a_call_moves_sp, i_clk, i_rst_n, stk_we |=> (r_sp == $past(r_sp) + SCW'(1)))

endmodule

// ----- sv/chip8_instruction_core.sv -----
// one request at a time; a draw reads and then rewrites each set sprite pixel in the display ram
// reset is synchronous, active low; afterwards a sweep loads the font, zeroes the
// memory and clears the display, with no request accepted until it ends
// ----------------------------------------------------------------------------
// chip8_instruction_core
// chip-8 interpreter core with memory, display store, registers and stack
// ----------------------------------------------------------------------------
module chip8_instruction_core #(
    parameter int STACK_DEPTH = c8ic_pkg::STACK_DEPTH,
    parameter int PIXEL_STORE = c8ic_pkg::PIXEL_STORE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_write_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic [15:0] o_opcode,
    output logic [11:0] o_program_counter,
    output logic        o_collision,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    c8ic_pkg::t_cmd       cmd;
    c8ic_pkg::t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    c8ic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (cmd)
    );

    c8ic_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .PIXEL_STORE (PIXEL_STORE)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_flags           (dp_status),
        .i_operation       (i_operation),
        .i_address         (i_address),
        .i_write_byte      (i_write_byte),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_read_data       (o_read_data),
        .o_opcode          (o_opcode),
        .o_program_counter (o_program_counter),
        .o_collision       (o_collision),
        .o_status          (o_status)
    );

endmodule
